### hdl/ile_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared constants, codes and the command bundle that drives the cell row.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int SWP_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_AT     = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     rd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

### hdl/ile_cell.sv
// ----------------------------------------------------------------------------
// Indexed list engine cell
// Holds one list entry, shifts with its neighbors and passes read data along.
// ----------------------------------------------------------------------------
module ile_cell (
  input  logic                             clk,
  input  logic [ile_pkg::POS_W-1:0]        index,
  input  ile_pkg::cell_cmd_t               cmd,
  input  logic signed [ile_pkg::DATA_W-1:0] left_data,
  input  logic signed [ile_pkg::DATA_W-1:0] right_data,
  input  logic signed [ile_pkg::DATA_W-1:0] rd_in,
  output logic signed [ile_pkg::DATA_W-1:0] data,
  output logic signed [ile_pkg::DATA_W-1:0] rd_out
);

  logic signed [ile_pkg::DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (index > cmd.pos) begin
        data_next = left_data;
      end else if (index == cmd.pos) begin
        data_next = cmd.value;
      end
    end else if (cmd.del) begin
      if (index >= cmd.pos) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data   <= data_next;
    rd_out <= (cmd.rd && (index == cmd.pos)) ? data : rd_in;
  end

endmodule

### hdl/ile_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list engine control
// Decodes commands, keeps the entry count, runs the read sweep and holds
// the result register.
// ----------------------------------------------------------------------------
module ile_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [2:0]                        operation,
  input  logic [ile_pkg::POS_W-1:0]         position,
  input  logic signed [ile_pkg::DATA_W-1:0] value,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [1:0]                        status,
  output logic signed [ile_pkg::DATA_W-1:0] read_value,
  output logic [ile_pkg::CNT_W-1:0]         length,
  input  logic signed [ile_pkg::DATA_W-1:0] tail_rd,
  output ile_pkg::cell_cmd_t                cell_cmd
);

  localparam logic [ile_pkg::CNT_W-1:0] FULL_CNT = ile_pkg::CNT_W'(ile_pkg::CAPACITY);
  localparam logic [ile_pkg::SWP_W-1:0] SWP_LAST = ile_pkg::SWP_W'(ile_pkg::CAPACITY);

  ile_pkg::state_t                    state;
  ile_pkg::state_t                    state_next;
  logic [ile_pkg::CNT_W-1:0]          count;
  logic [ile_pkg::CNT_W-1:0]          count_next;
  logic [ile_pkg::POS_W-1:0]          rd_pos;
  logic [ile_pkg::SWP_W-1:0]          sweep_cnt;
  logic                               accept;
  logic                               sweeping;
  logic                               sweep_done;
  logic                               ins_go;
  logic                               del_go;
  logic                               start_sweep;
  logic [ile_pkg::POS_W-1:0]          act_pos;
  ile_pkg::status_t                   imm_status;
  logic signed [ile_pkg::DATA_W-1:0]  imm_rd;
  logic                               full;

  assign accept     = cmd_valid && cmd_ready;
  assign full       = (count == FULL_CNT);
  assign sweep_done = sweeping && (sweep_cnt == SWP_LAST);

  always_comb begin
    ins_go      = 1'b0;
    del_go      = 1'b0;
    start_sweep = 1'b0;
    act_pos     = position;
    imm_status  = ile_pkg::ST_DONE;
    imm_rd      = '0;
    case (operation)
      ile_pkg::OP_READ: begin
        if (position < count) begin
          start_sweep = 1'b1;
        end else begin
          imm_status = ile_pkg::ST_RANGE;
          imm_rd     = '1;
        end
      end
      ile_pkg::OP_HEAD: begin
        act_pos = '0;
        if (full) begin
          imm_status = ile_pkg::ST_FULL;
        end else begin
          ins_go = 1'b1;
        end
      end
      ile_pkg::OP_TAIL: begin
        act_pos = count[ile_pkg::POS_W-1:0];
        if (full) begin
          imm_status = ile_pkg::ST_FULL;
        end else begin
          ins_go = 1'b1;
        end
      end
      ile_pkg::OP_AT: begin
        if (position > count) begin
          imm_status = ile_pkg::ST_RANGE;
        end else if (full) begin
          imm_status = ile_pkg::ST_FULL;
        end else begin
          ins_go = 1'b1;
        end
      end
      ile_pkg::OP_DELETE: begin
        if (position >= count) begin
          imm_status = ile_pkg::ST_RANGE;
        end else begin
          del_go = 1'b1;
        end
      end
      default: begin
        imm_status = ile_pkg::ST_DONE;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (accept && ins_go) begin
      count_next = count + ile_pkg::CNT_W'(1);
    end else if (accept && del_go) begin
      count_next = count - ile_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ile_pkg::S_IDLE: begin
        if (accept && start_sweep) begin
          state_next = ile_pkg::S_SWEEP;
        end
      end
      ile_pkg::S_SWEEP: begin
        if (sweep_cnt == SWP_LAST) begin
          state_next = ile_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ile_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    sweeping  = 1'b0;
    case (state)
      ile_pkg::S_IDLE: begin
        cmd_ready = !rsp_valid || rsp_ready;
      end
      ile_pkg::S_SWEEP: begin
        sweeping = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cell_cmd.ins   = accept && ins_go;
    cell_cmd.del   = accept && del_go;
    cell_cmd.rd    = sweeping;
    cell_cmd.pos   = sweeping ? rd_pos : act_pos;
    cell_cmd.value = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ile_pkg::S_IDLE;
      count     <= '0;
      sweep_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) begin
        sweep_cnt <= '0;
      end else if (sweeping) begin
        sweep_cnt <= sweep_cnt + ile_pkg::SWP_W'(1);
      end
      if ((accept && !start_sweep) || sweep_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_pos <= position;
    end
    if (accept && !start_sweep) begin
      status     <= imm_status;
      read_value <= imm_rd;
      length     <= count_next;
    end else if (sweep_done) begin
      status     <= ile_pkg::ST_DONE;
      read_value <= tail_rd;
      length     <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + ile_pkg::CNT_W'(1)) ||
             (count == $past(count) - ile_pkg::CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_sweep_count_stable: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> $stable(count))
    else $error("entry count changed during a read sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    sweep_done |=> rsp_valid && (state == ile_pkg::S_IDLE))
    else $error("read sweep ended without a result");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ile_pkg::ST_FULL) |-> (length == FULL_CNT))
    else $error("full status with a list that is not full");

endmodule

### hdl/indexed_list_engine_top.sv
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed 32-bit values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Inserts, deletes, out-of-range reads and unused operation codes load the
// result register at their transfer, so such commands can follow each other in
// every cycle while results are taken. An in-range read is answered once the
// read data has moved one cell per cycle down the row of 64 cells to the end
// of the row; no command is taken during the sweep. A new command is taken
// only when the result register is empty or its result is taken in the same
// cycle.
module indexed_list_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [2:0]                        operation,
  input  logic [ile_pkg::POS_W-1:0]         position,
  input  logic signed [ile_pkg::DATA_W-1:0] value,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [1:0]                        status,
  output logic signed [ile_pkg::DATA_W-1:0] read_value,
  output logic [ile_pkg::CNT_W-1:0]         length
);

  ile_pkg::cell_cmd_t                 cell_cmd;
  logic signed [ile_pkg::DATA_W-1:0]  cell_data [ile_pkg::CAPACITY];
  logic signed [ile_pkg::DATA_W-1:0]  cell_rd   [ile_pkg::CAPACITY];

  ile_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .read_value (read_value),
    .length     (length),
    .tail_rd    (cell_rd[ile_pkg::CAPACITY-1]),
    .cell_cmd   (cell_cmd)
  );

  for (genvar i = 0; i < ile_pkg::CAPACITY; i++) begin : g_cell
    logic signed [ile_pkg::DATA_W-1:0] left_data;
    logic signed [ile_pkg::DATA_W-1:0] right_data;
    logic signed [ile_pkg::DATA_W-1:0] rd_in;

    if (i == 0) begin : g_first
      assign left_data = cell_data[i];
      assign rd_in     = '0;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign rd_in     = cell_rd[i-1];
    end

    if (i == ile_pkg::CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    ile_cell u_cell (
      .clk        (clk),
      .index      (ile_pkg::POS_W'(i)),
      .cmd        (cell_cmd),
      .left_data  (left_data),
      .right_data (right_data),
      .rd_in      (rd_in),
      .data       (cell_data[i]),
      .rd_out     (cell_rd[i])
    );
  end

endmodule

### bench/tb_indexed_list_engine_top.sv
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Drives list commands through the command channel and checks every result
// against a list kept inside the bench. A short directed run covers the empty
// list, both value extremes, every operation, the unused operation codes and
// each out-of-range case. Random phases that grow, shrink and churn the list
// follow. The growing phases also reach the full list. Both channels idle in
// random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine_top;

  localparam int ITEM_TARGET    = 1350;
  localparam int QUIET_TAIL     = 200;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 90;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef enum int {GROW, SHRINK, CHURN} list_phase_t;

  typedef struct {
    logic [2:0]                        op;
    logic [ile_pkg::POS_W-1:0]         pos;
    logic signed [ile_pkg::DATA_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    ile_pkg::status_t                  status;
    logic signed [ile_pkg::DATA_W-1:0] read_value;
    logic [ile_pkg::CNT_W-1:0]         length;
  } list_result_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               cmd_valid = 1'b0;
  logic                               cmd_ready;
  logic [2:0]                         operation = '0;
  logic [ile_pkg::POS_W-1:0]          position = '0;
  logic signed [ile_pkg::DATA_W-1:0]  value = '0;
  logic                               rsp_valid;
  logic                               rsp_ready = 1'b0;
  logic [1:0]                         status;
  logic signed [ile_pkg::DATA_W-1:0]  read_value;
  logic [ile_pkg::CNT_W-1:0]          length;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  logic signed [ile_pkg::DATA_W-1:0] list_mem [ile_pkg::CAPACITY];
  int list_len = 0;
  int gen_len = 0;
  int total_cmds = 0;
  int cmds_taken = 0;
  int results_taken = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit cmd_taken = 1'b0;

  indexed_list_engine_top dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .read_value (read_value),
    .length     (length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic list_result_t predict_list_command(
      logic [2:0] op,
      logic [ile_pkg::POS_W-1:0] pos,
      logic signed [ile_pkg::DATA_W-1:0] val);
    list_result_t r;
    int slot;
    r.status = ile_pkg::ST_DONE;
    r.read_value = '0;
    slot = -1;
    case (op)
      ile_pkg::OP_READ: begin
        if (pos < list_len) begin
          r.read_value = list_mem[pos];
        end else begin
          r.status = ile_pkg::ST_RANGE;
          r.read_value = -1;
        end
      end
      ile_pkg::OP_HEAD: begin
        if (list_len >= ile_pkg::CAPACITY) r.status = ile_pkg::ST_FULL;
        else slot = 0;
      end
      ile_pkg::OP_TAIL: begin
        if (list_len >= ile_pkg::CAPACITY) r.status = ile_pkg::ST_FULL;
        else slot = list_len;
      end
      ile_pkg::OP_AT: begin
        if (pos > list_len) r.status = ile_pkg::ST_RANGE;
        else if (list_len >= ile_pkg::CAPACITY) r.status = ile_pkg::ST_FULL;
        else slot = pos;
      end
      ile_pkg::OP_DELETE: begin
        if (pos >= list_len) begin
          r.status = ile_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      default: ;
    endcase
    if (slot >= 0) begin
      for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i - 1];
      list_mem[slot] = val;
      list_len++;
    end
    r.length = list_len[ile_pkg::CNT_W-1:0];
    return r;
  endfunction

  // The stimulus side tracks only the list length, to aim positions in range.
  function automatic void queue_cmd(logic [2:0] op, int pos,
                                    logic signed [ile_pkg::DATA_W-1:0] val);
    list_cmd_t c;
    c.op = op;
    c.pos = pos[ile_pkg::POS_W-1:0];
    c.val = val;
    case (op)
      ile_pkg::OP_HEAD, ile_pkg::OP_TAIL: if (gen_len < ile_pkg::CAPACITY) gen_len++;
      ile_pkg::OP_AT: if (c.pos <= gen_len && gen_len < ile_pkg::CAPACITY) gen_len++;
      ile_pkg::OP_DELETE: if (c.pos < gen_len) gen_len--;
      default: ;
    endcase
    pending_cmds.push_back(c);
  endfunction

  function automatic logic signed [ile_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -1;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit idling_off();
    return ((cmds_taken / 200) % 3 == 2) || (cmds_taken + QUIET_TAIL >= total_cmds);
  endfunction

  initial begin : run_control
    list_phase_t phase;
    int chunk;
    int r;
    int wh;
    int wt;
    int wa;
    int wr;
    int wd;
    queue_cmd(ile_pkg::OP_READ, 0, rand_value());
    queue_cmd(ile_pkg::OP_DELETE, 0, rand_value());
    queue_cmd(ile_pkg::OP_AT, 1, rand_value());
    queue_cmd(ile_pkg::OP_AT, 0, 0);
    queue_cmd(ile_pkg::OP_HEAD, 0, 32'sh7fffffff);
    queue_cmd(ile_pkg::OP_TAIL, 0, 32'sh80000000);
    queue_cmd(ile_pkg::OP_AT, 3, -1);
    queue_cmd(ile_pkg::OP_AT, 2, 1);
    for (int i = 0; i < 5; i++) queue_cmd(ile_pkg::OP_READ, i, rand_value());
    queue_cmd(ile_pkg::OP_READ, 5, rand_value());
    queue_cmd(ile_pkg::OP_READ, 127, rand_value());
    queue_cmd(ile_pkg::OP_DELETE, 127, rand_value());
    queue_cmd(ile_pkg::OP_DELETE, 2, rand_value());
    queue_cmd(ile_pkg::OP_DELETE, 3, rand_value());
    queue_cmd(ile_pkg::OP_DELETE, 0, rand_value());
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      queue_cmd(3'(op), $urandom_range(0, 127), rand_value());
    end
    queue_cmd(ile_pkg::OP_AT, 127, rand_value());

    phase = GROW;
    while (pending_cmds.size() < ITEM_TARGET) begin
      chunk = $urandom_range(100, 160);
      if (chunk > ITEM_TARGET - pending_cmds.size()) begin
        chunk = ITEM_TARGET - pending_cmds.size();
      end
      case (phase)
        GROW: begin
          wh = 20; wt = 20; wa = 25; wr = 15; wd = 10;
        end
        SHRINK: begin
          wh = 5; wt = 5; wa = 10; wr = 20; wd = 50;
        end
        default: begin
          wh = 12; wt = 12; wa = 16; wr = 25; wd = 25;
        end
      endcase
      repeat (chunk) begin
        r = $urandom_range(0, 99);
        if (r < wh) begin
          queue_cmd(ile_pkg::OP_HEAD, $urandom_range(0, 127), rand_value());
        end else if (r < wh + wt) begin
          queue_cmd(ile_pkg::OP_TAIL, $urandom_range(0, 127), rand_value());
        end else if (r < wh + wt + wa) begin
          queue_cmd(ile_pkg::OP_AT, $urandom_range(0, gen_len), rand_value());
        end else if (r < wh + wt + wa + wr) begin
          queue_cmd(ile_pkg::OP_READ, gen_len > 0 ? $urandom_range(0, gen_len - 1)
                                                  : $urandom_range(0, 127), rand_value());
        end else if (r < wh + wt + wa + wr + wd) begin
          queue_cmd(ile_pkg::OP_DELETE, gen_len > 0 ? $urandom_range(0, gen_len - 1)
                                                    : $urandom_range(0, 127), rand_value());
        end else begin
          queue_cmd(3'($urandom_range(0, OP_SPARE_LAST)), $urandom_range(0, 127),
                    rand_value());
        end
      end
      phase = phase.next();
    end
    total_cmds = pending_cmds.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (cmds_taken != total_cmds || expected_results.size() != 0);
    repeat (ile_pkg::CAPACITY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS indexed_list_engine_top");
    end else begin
      $display("FAIL indexed_list_engine_top");
    end
    $finish;
  end

  always @(negedge clk) begin : cmd_driver
    list_cmd_t c;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (send_gap == 0 && !idling_off() && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 4);
      end
      if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        operation <= c.op;
        position  <= c.pos;
        value     <= c.val;
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : rsp_sink
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!hold_done && results_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (!idling_off() && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst) begin
      cmd_taken <= cmd_valid && cmd_ready;
      if (rsp_valid && rsp_ready) begin
        results_taken <= results_taken + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d read_value %0d length %0d",
                   $time, status, read_value, length);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatch_count++;
          end
          if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, want.read_value, read_value);
            mismatch_count++;
          end
          if (length !== want.length) begin
            $display("%0t: length expected %0d actual %0d", $time, want.length, length);
            mismatch_count++;
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        expected_results.push_back(predict_list_command(operation, position, value));
        cmds_taken <= cmds_taken + 1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL indexed_list_engine_top");
      $finish;
    end
  end

endmodule
